### hw/rtl/prrb_pkg.sv
// shared types and constants for the packet record ring buffer
package prrb_pkg;

  localparam int DEFAULT_DEPTH = 1024;

  localparam int REC_W     = 64;   // packet id and arrival time width
  localparam int RIDX_W    = 10;   // read index field width
  localparam int IDX_OUT_W = 11;   // oldest and newest index field width
  localparam int WSTART_W  = 10;   // window start field width
  localparam int WIN_W     = 11;   // window size register width

  localparam logic [WIN_W-1:0] WINDOW_RESET = 11'd1024;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

endpackage

### hw/rtl/prrb_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module prrb_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/packet_record_ring_buffer.sv
// packet record ring buffer: overwriting history of packet records with status outputs
// a result passes the ram read register and read stage, then the output register
// throughput: one item per cycle, limited by the single ram read port and write port
// back-pressure on the output stalls the read stage, which then holds off new items
// reset (synchronous, active high): empty buffer, slot zero next, window size 1024
// record storage is not cleared; a slot reads valid once it has been written
module packet_record_ring_buffer #(
  parameter int DEPTH = prrb_pkg::DEFAULT_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [prrb_pkg::WIN_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 op,
  input  logic [prrb_pkg::REC_W-1:0]           pkt_id,
  input  logic [prrb_pkg::REC_W-1:0]           arrival_time,
  input  logic [prrb_pkg::RIDX_W-1:0]          read_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [prrb_pkg::REC_W-1:0]           read_pkt_id,
  output logic [prrb_pkg::REC_W-1:0]           read_arrival_time,
  output logic                                 is_empty,
  output logic signed [prrb_pkg::IDX_OUT_W-1:0] oldest_index,
  output logic signed [prrb_pkg::IDX_OUT_W-1:0] newest_index,
  output logic [prrb_pkg::WSTART_W-1:0]        window_start
);
  import prrb_pkg::*;

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int LW     = SLOT_W + 1;
  localparam int WW     = (LW > WIN_W) ? LW : WIN_W;

  // pointer state
  logic [SLOT_W-1:0] next_slot, next_slot_next;
  logic [SLOT_W-1:0] newest_slot, newest_slot_next;
  logic              filled, filled_next;
  logic              wrapped, wrapped_next;
  logic [WIN_W-1:0]  window_size;

  // read stage
  logic              p_valid;
  logic              p_hit;
  logic              p_filled;
  logic              p_wrapped;
  logic [SLOT_W-1:0] p_next;
  logic [SLOT_W-1:0] p_newest;
  logic              p_move;

  logic              accept;
  logic              is_ins;
  logic              idx_hit;
  logic [2*REC_W-1:0] ram_rdata;

  assign p_move   = p_valid && (!out_valid || out_ready);
  assign in_ready = !p_valid || p_move;
  assign accept   = in_valid && in_ready;
  assign is_ins   = (op == OP_INSERT);
  assign idx_hit  = (WW'(read_index) < WW'(DEPTH));

  always_comb begin
    next_slot_next   = next_slot;
    newest_slot_next = newest_slot;
    filled_next      = filled;
    wrapped_next     = wrapped;
    if (is_ins) begin
      newest_slot_next = next_slot;
      filled_next      = 1'b1;
      if (next_slot == SLOT_W'(DEPTH - 1)) begin
        next_slot_next = '0;
        wrapped_next   = 1'b1;
      end else begin
        next_slot_next = next_slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot   <= '0;
      newest_slot <= '0;
      filled      <= 1'b0;
      wrapped     <= 1'b0;
      window_size <= WINDOW_RESET;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_wdata;
      end
      if (accept) begin
        next_slot   <= next_slot_next;
        newest_slot <= newest_slot_next;
        filled      <= filled_next;
        wrapped     <= wrapped_next;
      end
    end
  end

  prrb_ram #(
    .WIDTH (2 * REC_W),
    .DEPTH (DEPTH)
  ) u_rec_ram (
    .clk   (clk),
    .we    (accept && is_ins),
    .waddr (next_slot),
    .wdata ({pkt_id, arrival_time}),
    .re    (accept && !is_ins && idx_hit),
    .raddr (SLOT_W'(read_index)),
    .rdata (ram_rdata)
  );

  // read stage carries the status as it stands after its own beat
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_hit     <= !is_ins && idx_hit;
      p_filled  <= filled_next;
      p_wrapped <= wrapped_next;
      p_next    <= next_slot_next;
      p_newest  <= newest_slot_next;
    end
  end

  // window start from the read stage status
  logic [WW-1:0] w_raw, w_eff, e_cnt, ws;

  always_comb begin
    w_raw = WW'(window_size);
    if (w_raw == '0) begin
      w_eff = WW'(1);
    end else if (w_raw > WW'(DEPTH)) begin
      w_eff = WW'(DEPTH);
    end else begin
      w_eff = w_raw;
    end
    e_cnt = p_filled ? (WW'(p_newest) + WW'(1)) : '0;
    if (e_cnt >= w_eff) begin
      ws = e_cnt - w_eff;
    end else if (p_wrapped) begin
      ws = WW'(DEPTH) + e_cnt - w_eff;
    end else begin
      ws = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      read_pkt_id       <= p_hit ? ram_rdata[2*REC_W-1:REC_W] : '0;
      read_arrival_time <= p_hit ? ram_rdata[REC_W-1:0] : '0;
      is_empty          <= !p_filled;
      if (!p_filled) begin
        oldest_index <= '1;
      end else if (!p_wrapped) begin
        oldest_index <= '0;
      end else begin
        oldest_index <= IDX_OUT_W'(p_next);
      end
      newest_index <= p_filled ? IDX_OUT_W'(p_newest) : '1;
      window_start <= WSTART_W'(ws);
    end
  end

`ifndef ASSERT_OFF
  // an accepted insert leaves the buffer non-empty
  assert property (@(posedge clk) disable iff (rst)
    accept && is_ins |=> filled)
    else $error("insert did not mark buffer filled");

  // wrap can only follow inserts
  assert property (@(posedge clk) disable iff (rst)
    wrapped |-> filled)
    else $error("wrapped set on empty buffer");

  // a stalled read stage must keep its ram data
  assert property (@(posedge clk) disable iff (rst)
    p_valid && !p_move |=> $stable(ram_rdata))
    else $error("ram data changed under stalled beat");

  // empty results report both indexes as minus one
  assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> (newest_index == '1) && (oldest_index == '1))
    else $error("empty result with valid index");
`endif

endmodule
